FILE: rtl/radlr_pkg.sv
// ----------------------------------------------------------------------------
// radlr_pkg
// Shared widths, constants and types of the rolling Adler-32 window unit.
// ----------------------------------------------------------------------------
package radlr_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned WS_W   = 11;

  // adler modulus and reset value of the window length register
  localparam logic [SUM_W:0]  ADLER_MOD = 17'd65521;
  localparam logic [WS_W-1:0] WS_RESET  = 11'd1024;

  // item as it leaves the position stage
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              restart;
    logic              drop_en;   // window already full: oldest byte leaves
    logic              full_out;  // full flag after this item
    logic [WS_W-1:0]   win_len;   // effective window length
  } item_t;

endpackage

FILE: rtl/radlr_ram.sv
// ----------------------------------------------------------------------------
// radlr_ram
// Generic single-clock RAM, one write and one read port, registered read.
// A read and a write of the same entry in one cycle returns the old data.
// ----------------------------------------------------------------------------
module radlr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first storage
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/radlr_ctrl.sv
// ----------------------------------------------------------------------------
// radlr_ctrl
// Input stage: write position, full flag and window store access.
// Each accepted item reads the oldest byte and writes the new byte at the
// same slot in the same cycle.
// ----------------------------------------------------------------------------
module radlr_ctrl #(
  parameter int unsigned WINDOW_MAX = 1024,
  localparam int unsigned PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [radlr_pkg::WS_W-1:0]     window_size_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [radlr_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                           restart_i,
  output logic                           s1_valid_o,
  input  logic                           s1_ready_i,
  output radlr_pkg::item_t               s1_item_o,
  output logic                           ram_en_o,
  output logic [PW-1:0]                  ram_addr_o
);

  logic [PW-1:0]              pos_q, pos_d;
  logic                       full_q, full_d;
  logic                       s1_valid_q;
  radlr_pkg::item_t           s1_item_q, item_d;
  logic [radlr_pkg::WS_W-1:0] n_eff;
  logic [PW-1:0]              pos_start, pos_cur;
  logic                       full_start, full_cur;
  logic                       accept;

  // clamp window length to 1..WINDOW_MAX
  always_comb begin
    if (window_size_i == '0) begin
      n_eff = radlr_pkg::WS_W'(1);
    end else if (32'(window_size_i) > WINDOW_MAX) begin
      n_eff = radlr_pkg::WS_W'(WINDOW_MAX);
    end else begin
      n_eff = window_size_i;
    end
  end

  // restart, wrap when the window shrank below the position, then advance it
  always_comb begin
    pos_start  = restart_i ? '0 : pos_q;
    full_start = restart_i ? 1'b0 : full_q;
    if (32'(pos_start) >= 32'(n_eff)) begin
      pos_cur  = '0;
      full_cur = 1'b1;
    end else begin
      pos_cur  = pos_start;
      full_cur = full_start;
    end
    if (32'(pos_cur) + 32'd1 >= 32'(n_eff)) begin
      pos_d  = '0;
      full_d = 1'b1;
    end else begin
      pos_d  = pos_cur + PW'(1);
      full_d = full_cur;
    end
  end

  // item for the checksum stages
  always_comb begin
    item_d.data_byte = data_byte_i;
    item_d.restart   = restart_i;
    item_d.drop_en   = full_cur;
    item_d.full_out  = full_d;
    item_d.win_len   = n_eff;
  end

  assign in_ready_o = !s1_valid_q || s1_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // position and full flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      full_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      full_q <= full_d;
    end
  end

  // stage register, lined up with the store read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;
  assign ram_en_o   = accept;
  assign ram_addr_o = pos_cur;

endmodule

FILE: rtl/radlr_sums.sv
// ----------------------------------------------------------------------------
// radlr_sums
// Checksum stages: fold the dropped byte term modulo 65521, then update
// sums a and b and register the result item.
// ----------------------------------------------------------------------------
module radlr_sums (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s1_valid_i,
  output logic                           s1_ready_o,
  input  radlr_pkg::item_t               s1_item_i,
  input  logic [radlr_pkg::BYTE_W-1:0]   old_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2*radlr_pkg::SUM_W-1:0]  checksum_o,
  output logic                           window_full_o
);

  localparam int unsigned PROD_W = radlr_pkg::WS_W + radlr_pkg::BYTE_W;
  localparam int unsigned T_W    = radlr_pkg::SUM_W + 2;

  logic [PROD_W-1:0]               prod;
  logic [radlr_pkg::SUM_W:0]       fold;
  logic [radlr_pkg::SUM_W-1:0]     drop_d;

  logic                            s2_valid_q;
  logic [radlr_pkg::BYTE_W-1:0]    s2_byte_q, s2_old_q;
  logic                            s2_restart_q, s2_drop_en_q, s2_full_q;
  logic [radlr_pkg::SUM_W-1:0]     s2_drop_q;

  logic [radlr_pkg::SUM_W-1:0]     a_q, b_q, a_base, b_base, a_new, b_new;
  logic [radlr_pkg::BYTE_W-1:0]    sub_a;
  logic [radlr_pkg::SUM_W-1:0]     sub_b;
  logic signed [T_W-1:0]           ta, tb, mod_s;

  logic                            out_valid_q, out_full_q;
  logic [2*radlr_pkg::SUM_W-1:0]   checksum_q;
  logic                            adv_out;

  // (n * old + 1) mod 65521, using 2^16 = 15 mod 65521
  always_comb begin
    prod   = PROD_W'(s1_item_i.win_len) * PROD_W'(old_byte_i);
    fold   = {1'b0, prod[radlr_pkg::SUM_W-1:0]}
           + (radlr_pkg::SUM_W + 1)'(prod[PROD_W-1:radlr_pkg::SUM_W])
             * (radlr_pkg::SUM_W + 1)'(15)
           + (radlr_pkg::SUM_W + 1)'(1);
    if (fold >= radlr_pkg::ADLER_MOD) begin
      drop_d = radlr_pkg::SUM_W'(fold - radlr_pkg::ADLER_MOD);
    end else begin
      drop_d = fold[radlr_pkg::SUM_W-1:0];
    end
  end

  assign adv_out    = !out_valid_q || out_ready_i;
  assign s1_ready_o = !s2_valid_q || adv_out;

  // stage two register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      s2_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      s2_byte_q    <= s1_item_i.data_byte;
      s2_old_q     <= old_byte_i;
      s2_restart_q <= s1_item_i.restart;
      s2_drop_en_q <= s1_item_i.drop_en;
      s2_full_q    <= s1_item_i.full_out;
      s2_drop_q    <= drop_d;
    end
  end

  // sum update: drop oldest byte, add the new one, each with one correction
  always_comb begin
    mod_s  = T_W'($signed({1'b0, radlr_pkg::ADLER_MOD}));
    a_base = s2_restart_q ? radlr_pkg::SUM_W'(1) : a_q;
    b_base = s2_restart_q ? '0 : b_q;
    sub_a  = s2_drop_en_q ? s2_old_q : '0;
    sub_b  = s2_drop_en_q ? s2_drop_q : '0;

    ta = $signed(T_W'(a_base)) + $signed(T_W'(s2_byte_q)) - $signed(T_W'(sub_a));
    if (ta < 0) begin
      a_new = radlr_pkg::SUM_W'(ta + mod_s);
    end else if (ta >= mod_s) begin
      a_new = radlr_pkg::SUM_W'(ta - mod_s);
    end else begin
      a_new = ta[radlr_pkg::SUM_W-1:0];
    end

    tb = $signed(T_W'(b_base)) - $signed(T_W'(sub_b)) + $signed(T_W'(a_new));
    if (tb < 0) begin
      b_new = radlr_pkg::SUM_W'(tb + mod_s);
    end else if (tb >= mod_s) begin
      b_new = radlr_pkg::SUM_W'(tb - mod_s);
    end else begin
      b_new = tb[radlr_pkg::SUM_W-1:0];
    end
  end

  // running sums and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= radlr_pkg::SUM_W'(1);
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s2_valid_q;
      if (s2_valid_q) begin
        a_q <= a_new;
        b_q <= b_new;
      end
    end
  end

  // result item register
  always_ff @(posedge clk_i) begin
    if (adv_out && s2_valid_q) begin
      checksum_q <= {b_new, a_new};
      out_full_q <= s2_full_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign checksum_o    = checksum_q;
  assign window_full_o = out_full_q;

endmodule

FILE: rtl/rolling_adler32_window_unit.sv
// ----------------------------------------------------------------------------
// rolling_adler32_window_unit
// Rolling Adler-32 checksum over the last window_size bytes of a stream.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless the output stalls and returns one item per
// byte via the stage one, two and result registers. The window bytes live in
// a single RAM of WINDOW_MAX bytes; each item reads the oldest byte and writes
// the new one at the same slot in its accept cycle, so one RAM access per item
// sets the rate of one item per cycle. The sums loop in the last stage. No
// clearing pass follows reset: the user must ensure a slot is read as oldest
// byte only once written since the last restart; the unit does not enforce it.
// window_size is written through cfg_we_i / cfg_wdata_i by the user only while
// idle (unit does not enforce it). 0 acts as 1, above WINDOW_MAX as WINDOW_MAX.
// ----------------------------------------------------------------------------
module rolling_adler32_window_unit #(
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [radlr_pkg::WS_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [radlr_pkg::BYTE_W-1:0]   data_byte_i,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2*radlr_pkg::SUM_W-1:0]  checksum_o,
  output logic                           window_full_o
);

  localparam int unsigned PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [radlr_pkg::WS_W-1:0]   window_size_q;
  logic                         s1_valid, s1_ready;
  radlr_pkg::item_t             s1_item;
  logic                         ram_en;
  logic [PW-1:0]                ram_addr;
  logic [radlr_pkg::BYTE_W-1:0] old_byte;

  // window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= radlr_pkg::WS_RESET;
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  // position and store access
  radlr_ctrl #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_size_i (window_size_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .restart_i     (restart_i),
    .s1_valid_o    (s1_valid),
    .s1_ready_i    (s1_ready),
    .s1_item_o     (s1_item),
    .ram_en_o      (ram_en),
    .ram_addr_o    (ram_addr)
  );

  // window byte store
  radlr_ram #(
    .WIDTH (radlr_pkg::BYTE_W),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_en),
    .waddr_i (ram_addr),
    .wdata_i (data_byte_i),
    .re_i    (ram_en),
    .raddr_i (ram_addr),
    .rdata_o (old_byte)
  );

  // checksum arithmetic and result register
  radlr_sums u_sums (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s1_valid_i    (s1_valid),
    .s1_ready_o    (s1_ready),
    .s1_item_i     (s1_item),
    .old_byte_i    (old_byte),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .checksum_o    (checksum_o),
    .window_full_o (window_full_o)
  );

  // store slot stays inside the current window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_en |-> (32'(ram_addr) < WINDOW_MAX) &&
               ((32'(ram_addr) < 32'(window_size_q)) || (ram_addr == '0)))
    else $error("window store slot outside the window");

  // both sums of a result are reduced modulo 65521
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, checksum_o[15:0]} < radlr_pkg::ADLER_MOD) &&
                    ({1'b0, checksum_o[31:16]} < radlr_pkg::ADLER_MOD))
    else $error("checksum sum not reduced");

  // a result item appears only after an item went through the stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_ready) || $past(out_ready_i))
    else $error("result item without a stage two item");

endmodule

FILE: verif/tb_rolling_adler32_window_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rolling_adler32_window_unit
// Self-checking bench for the rolling Adler-32 window unit.
// ----------------------------------------------------------------------------
// A short directed run covers the extreme bytes, restarts and window lengths
// of 0, 1 and the reset length. Random streams follow over many window
// lengths: mostly short windows, one long stream that runs past the end of a
// 300-byte window, a window lowered mid-stream, and lengths above the
// maximum. A checksum tracker predicts every result item and compares it
// field by field. The sender idles in bursts, the receiver stalls in
// patterns, and once it holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_rolling_adler32_window_unit;

  localparam int unsigned WIN_MAX     = 1024;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned CFG_SETTLE  = 5;
  localparam int unsigned LONG_HOLD   = 80;

  // one expected result item
  typedef struct packed {
    logic [2*radlr_pkg::SUM_W-1:0] checksum;
    logic                          window_full;
  } checksum_item_t;

  // running checksum prediction and store of pending results
  class window_checksum_tracker;
    logic [radlr_pkg::SUM_W-1:0]  sum_a;
    logic [radlr_pkg::SUM_W-1:0]  sum_b;
    logic [radlr_pkg::BYTE_W-1:0] byte_ring [WIN_MAX];
    bit                           written [WIN_MAX];
    int unsigned                  wr_pos;
    bit                           full;
    logic [radlr_pkg::WS_W-1:0]   win_len;
    checksum_item_t               expected_sums [$];
    int unsigned                  bad_results;

    function new();
      sum_a       = radlr_pkg::SUM_W'(1);
      sum_b       = '0;
      wr_pos      = 0;
      full        = 0;
      win_len     = radlr_pkg::WS_RESET;
      bad_results = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_window(logic [radlr_pkg::WS_W-1:0] value);
      win_len = value;
    endfunction

    function int unsigned span();
      if (win_len == 0) return 1;
      if (win_len > WIN_MAX) return WIN_MAX;
      return win_len;
    endfunction

    // true when a byte without restart would remove a slot not yet written
    function bit needs_restart();
      int unsigned pos;
      bit          f;
      pos = wr_pos;
      f   = full;
      if (pos >= span()) begin
        pos = 0;
        f   = 1;
      end
      return f && !written[pos];
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction

    // accepted input item: roll the window and queue the expected checksum
    function void take_byte(logic [radlr_pkg::BYTE_W-1:0] data, logic restart);
      int unsigned    n;
      int unsigned    a;
      int unsigned    b;
      int unsigned    oldest;
      int unsigned    drop_b;
      checksum_item_t want;
      n = span();
      a = sum_a;
      b = sum_b;
      if (restart) begin
        a      = 1;
        b      = 0;
        wr_pos = 0;
        full   = 0;
        foreach (written[i]) written[i] = 0;
      end
      // position past a lowered window wraps and marks the window full
      if (wr_pos >= n) begin
        wr_pos = 0;
        full   = 1;
      end
      // oldest byte leaves the window
      if (full) begin
        oldest = byte_ring[wr_pos];
        drop_b = (n * oldest + 1) % radlr_pkg::ADLER_MOD;
        a = (a + radlr_pkg::ADLER_MOD - oldest) % radlr_pkg::ADLER_MOD;
        b = (b + radlr_pkg::ADLER_MOD - drop_b) % radlr_pkg::ADLER_MOD;
      end
      a = (a + data) % radlr_pkg::ADLER_MOD;
      b = (b + a) % radlr_pkg::ADLER_MOD;
      byte_ring[wr_pos] = data;
      written[wr_pos]   = 1;
      wr_pos++;
      if (wr_pos >= n) begin
        wr_pos = 0;
        full   = 1;
      end
      sum_a = a[radlr_pkg::SUM_W-1:0];
      sum_b = b[radlr_pkg::SUM_W-1:0];
      want.checksum    = {sum_b, sum_a};
      want.window_full = full;
      expected_sums.push_back(want);
    endfunction

    function void report_bad(string msg);
      bad_results++;
      if (bad_results <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // result item: compare with the oldest expectation
    function void check_checksum(logic [2*radlr_pkg::SUM_W-1:0] checksum,
                                 logic window_full);
      checksum_item_t want;
      if (expected_sums.size() == 0) begin
        report_bad($sformatf("unexpected item checksum=%h full=%b", checksum, window_full));
        return;
      end
      want = expected_sums.pop_front();
      if (checksum !== want.checksum)
        report_bad($sformatf("checksum expected %h got %h", want.checksum, checksum));
      if (window_full !== want.window_full)
        report_bad($sformatf("window_full expected %b got %b",
                             want.window_full, window_full));
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [radlr_pkg::WS_W-1:0]      cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [radlr_pkg::BYTE_W-1:0]    data_byte_i;
  logic                            restart_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [2*radlr_pkg::SUM_W-1:0]   checksum_o;
  logic                            window_full_o;

  window_checksum_tracker tracker;
  int unsigned            results_seen;
  int unsigned            burst_left;
  bit                     long_hold_done;

  rolling_adler32_window_unit #(
    .WINDOW_MAX(WIN_MAX)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .checksum_o   (checksum_o),
    .window_full_o(window_full_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offer one byte and hold it until taken
  task automatic send_byte(input logic [radlr_pkg::BYTE_W-1:0] data, input logic restart);
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    restart_i   <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_byte(data, restart);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // write the window length once every result is back
  task automatic program_window(input logic [radlr_pkg::WS_W-1:0] value);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_window(value);
  endtask

  function automatic logic [radlr_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'hFF;
      2:       return 8'h00;
      default: return radlr_pkg::BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // random stream in bursts; restart is forced before an unwritten slot
  task automatic run_stream(input logic [radlr_pkg::WS_W-1:0] win,
                            input int unsigned count);
    logic restart;
    program_window(win);
    repeat (count) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      restart = ($urandom_range(0, 39) == 0) || tracker.needs_restart();
      send_byte(pick_byte(), restart);
      burst_left--;
    end
  endtask

  function automatic logic [radlr_pkg::WS_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      7:       return radlr_pkg::WS_W'($urandom_range(41, 300));
      8:       return radlr_pkg::WS_W'($urandom_range(1000, 1024));
      9:       return radlr_pkg::WS_W'($urandom_range(0, 2047));
      default: return radlr_pkg::WS_W'($urandom_range(1, 40));
    endcase
  endfunction

  // receiver: stall patterns, and one long hold-off once traffic is flowing
  initial begin
    int unsigned mode;
    int unsigned span_len;
    int unsigned k;
    wait (rst_ni === 1'b1);
    forever begin
      if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      mode     = $urandom_range(0, 3);
      span_len = $urandom_range(20, 150);
      for (k = 0; k < span_len; k++) begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (k % 3 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_checksum(checksum_o, window_full_o);
      results_seen++;
    end
  end

  // watchdog on cycles with no item moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned p;
    tracker        = new();
    results_seen   = 0;
    burst_left     = 0;
    long_hold_done = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    data_byte_i <= '0;
    restart_i   <= 1'b0;
    out_ready_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window length, extreme bytes and a restart
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b0);
    // window of one, lowered mid-stream so the position wraps
    program_window(11'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // zero acts as one
    program_window(11'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);

    // above the maximum, then a long stream that rolls a mid-size window
    run_stream(11'd2047, 30);
    run_stream(11'd300, 330);
    // lowered without restart, then raised again
    run_stream(11'd16, 40);
    run_stream(11'd5, 30);
    run_stream(11'd23, 40);
    for (p = 0; p < 5; p++) run_stream(pick_window(), $urandom_range(30, 70));

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.bad_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/radlr_pkg.sv
rtl/radlr_ram.sv
rtl/radlr_ctrl.sv
rtl/radlr_sums.sv
rtl/rolling_adler32_window_unit.sv
verif/tb_rolling_adler32_window_unit.sv
